[sv/sde_pkg.sv]
// ----------------------------------------------------------------------------
// sde_pkg
// shared types, codes and the double equality test for the set difference
// engine
// ----------------------------------------------------------------------------
package sde_pkg;

  localparam int SET_SIZE_DEF = 16;

  // input modes
  localparam logic [1:0] MODE_LOAD_X  = 2'd0;
  localparam logic [1:0] MODE_LOAD_Y  = 2'd1;
  localparam logic [1:0] MODE_COMPUTE = 2'd2;

  // result status codes
  localparam logic [2:0] ST_ACCEPT = 3'd0;
  localparam logic [2:0] ST_DUP    = 3'd1;
  localparam logic [2:0] ST_FULL   = 3'd2;
  localparam logic [2:0] ST_ELEM   = 3'd3;
  localparam logic [2:0] ST_EMPTY  = 3'd4;

  typedef struct packed {
    logic [1:0]  mode;
    logic [63:0] value;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [63:0] value_res;
    logic [4:0]  count;
    logic        last;
  } out_item_t;

  function automatic logic is_nan(input logic [63:0] a);
    return (a[62:52] == 11'h7ff) && (a[51:0] != 52'd0);
  endfunction

  // ieee double equality: zeros of either sign are equal, nan equals nothing
  function automatic logic fp_eq(input logic [63:0] a, input logic [63:0] b);
    return !is_nan(a) && !is_nan(b) &&
           ((a == b) || ((a[62:0] == 63'd0) && (b[62:0] == 63'd0)));
  endfunction

endpackage

[sv/sde_if.sv]
// ----------------------------------------------------------------------------
// sde_if
// valid/ready channels for input items and result items
// ----------------------------------------------------------------------------
interface sde_in_if;
  logic              valid;
  logic              ready;
  sde_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface sde_out_if;
  logic               valid;
  logic               ready;
  sde_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[sv/set_difference_engine_unit.sv]
// ----------------------------------------------------------------------------
// set_difference_engine_unit
// two sets of double values with duplicate check and ordered x \ y output
// ----------------------------------------------------------------------------
// Sets X and Y live in two SET_SIZE x 64 synchronous memories (registered
// read). One item is worked at a time; in_ch.ready is high only when idle.
// A load scans the target set one entry at a time (read, compare) until a
// match or the end, then appends the value if it is new and the set is not
// full, and returns one beat. A compute walks X; for each entry it scans Y
// until a match, marks survivors in a keep vector and counts them, then
// replays the kept X entries as result beats carrying the final count. An
// empty difference gives one beat with status empty. Results leave through
// a single output register, so the next item is taken while the last beat
// still waits. Mode 3 is consumed with no result. No clearing pass:
// entries beyond the counts are never read.
// ----------------------------------------------------------------------------
module set_difference_engine_unit #(
  parameter int SET_SIZE = sde_pkg::SET_SIZE_DEF
) (
  input logic           clk,
  input logic           rst_n,
  sde_in_if.sink        in_ch,
  sde_out_if.source     out_ch
);

  localparam int IW = (SET_SIZE > 1) ? $clog2(SET_SIZE) : 1;
  localparam int CW = $clog2(SET_SIZE + 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(SET_SIZE);
  localparam logic [CW-1:0] ONE      = CW'(1);

  // sequencer states
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_LRD   = 4'd1;   // load scan: read issued
  localparam logic [3:0] S_LCMP  = 4'd2;   // load scan: compare
  localparam logic [3:0] S_LDONE = 4'd3;   // append and report
  localparam logic [3:0] S_XRD   = 4'd4;   // read x entry
  localparam logic [3:0] S_XUSE  = 4'd5;   // latch x entry
  localparam logic [3:0] S_YRD   = 4'd6;   // read y entry
  localparam logic [3:0] S_YCMP  = 4'd7;   // compare x against y
  localparam logic [3:0] S_ERD   = 4'd8;   // find next kept x entry
  localparam logic [3:0] S_EOUT  = 4'd9;   // emit kept entry
  localparam logic [3:0] S_EMPTY = 4'd10;  // emit empty marker

  // set storage
  logic [63:0] mem_x [SET_SIZE];
  logic [63:0] mem_y [SET_SIZE];
  logic [63:0] xq_r, yq_r;

  logic [3:0]          state_r, state_nxt;
  logic [CW-1:0]       count_x_r, count_x_nxt, count_y_r, count_y_nxt;
  logic [CW-1:0]       i_r, i_nxt, j_r, j_nxt, n_r, n_nxt, e_r, e_nxt;
  logic [SET_SIZE-1:0] keep_r, keep_nxt;
  logic                sel_y_r, sel_y_nxt, dup_r, dup_nxt;
  logic [63:0]         val_r, val_nxt, xv_r, xv_nxt;
  logic                out_valid_r, out_valid_nxt;
  sde_pkg::out_item_t  out_data_r, out_data_nxt;

  // memory control
  logic          wr_x, wr_y;
  logic [IW-1:0] x_ra, y_ra, wa;

  logic          slot_free;
  logic          in_beat;
  logic [CW-1:0] cnt_sel;
  logic [63:0]   q_sel;

  assign in_ch.ready  = (state_r == S_IDLE);
  assign in_beat      = in_ch.valid && in_ch.ready;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;
  assign slot_free    = !out_valid_r || out_ch.ready;

  assign cnt_sel = sel_y_r ? count_y_r : count_x_r;
  assign q_sel   = sel_y_r ? yq_r : xq_r;
  assign x_ra    = i_r[IW-1:0];
  assign y_ra    = ((state_r == S_YRD) || (state_r == S_YCMP)) ? j_r[IW-1:0] : i_r[IW-1:0];
  assign wa      = cnt_sel[IW-1:0];

  always_comb begin
    state_nxt     = state_r;
    count_x_nxt   = count_x_r;
    count_y_nxt   = count_y_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    n_nxt         = n_r;
    e_nxt         = e_r;
    keep_nxt      = keep_r;
    sel_y_nxt     = sel_y_r;
    dup_nxt       = dup_r;
    val_nxt       = val_r;
    xv_nxt        = xv_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_data_nxt  = out_data_r;
    wr_x          = 1'b0;
    wr_y          = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_beat) begin
          i_nxt   = '0;
          dup_nxt = 1'b0;
          if (in_ch.data.mode == sde_pkg::MODE_LOAD_X ||
              in_ch.data.mode == sde_pkg::MODE_LOAD_Y) begin
            sel_y_nxt = (in_ch.data.mode == sde_pkg::MODE_LOAD_Y);
            val_nxt   = in_ch.data.value;
            if (((in_ch.data.mode == sde_pkg::MODE_LOAD_Y) ? count_y_r : count_x_r) == '0)
              state_nxt = S_LDONE;
            else
              state_nxt = S_LRD;
          end else if (in_ch.data.mode == sde_pkg::MODE_COMPUTE) begin
            n_nxt    = '0;
            keep_nxt = '0;
            state_nxt = (count_x_r == '0) ? S_EMPTY : S_XRD;
          end
        end
      end
      S_LRD: state_nxt = S_LCMP;
      S_LCMP: begin
        if (sde_pkg::fp_eq(q_sel, val_r)) begin
          dup_nxt   = 1'b1;
          state_nxt = S_LDONE;
        end else if (i_r + ONE == cnt_sel) begin
          state_nxt = S_LDONE;
        end else begin
          i_nxt     = i_r + ONE;
          state_nxt = S_LRD;
        end
      end
      S_LDONE: begin
        if (slot_free) begin
          out_valid_nxt          = 1'b1;
          out_data_nxt.value_res = val_r;
          out_data_nxt.last      = 1'b1;
          out_data_nxt.count     = 5'(cnt_sel);
          if (dup_r) begin
            out_data_nxt.status = sde_pkg::ST_DUP;
          end else if (cnt_sel >= FULL_CNT) begin
            out_data_nxt.status = sde_pkg::ST_FULL;
          end else begin
            out_data_nxt.status = sde_pkg::ST_ACCEPT;
            out_data_nxt.count  = 5'(cnt_sel + ONE);
            if (sel_y_r) begin
              wr_y        = 1'b1;
              count_y_nxt = count_y_r + ONE;
            end else begin
              wr_x        = 1'b1;
              count_x_nxt = count_x_r + ONE;
            end
          end
          state_nxt = S_IDLE;
        end
      end
      S_XRD: state_nxt = S_XUSE;
      S_XUSE: begin
        xv_nxt = xq_r;
        j_nxt  = '0;
        if (count_y_r == '0) begin
          keep_nxt[i_r[IW-1:0]] = 1'b1;
          n_nxt = n_r + ONE;
          if (i_r + ONE == count_x_r) begin
            i_nxt = '0;
            e_nxt = '0;
            state_nxt = S_ERD;
          end else begin
            i_nxt = i_r + ONE;
            state_nxt = S_XRD;
          end
        end else begin
          state_nxt = S_YRD;
        end
      end
      S_YRD: state_nxt = S_YCMP;
      S_YCMP: begin
        if (!sde_pkg::fp_eq(yq_r, xv_r) && (j_r + ONE != count_y_r)) begin
          j_nxt     = j_r + ONE;
          state_nxt = S_YRD;
        end else begin
          // x entry settled: matched, or survived every y entry
          if (!sde_pkg::fp_eq(yq_r, xv_r)) begin
            keep_nxt[i_r[IW-1:0]] = 1'b1;
            n_nxt = n_r + ONE;
          end
          if (i_r + ONE == count_x_r) begin
            i_nxt = '0;
            e_nxt = '0;
            state_nxt = (n_nxt == '0) ? S_EMPTY : S_ERD;
          end else begin
            i_nxt = i_r + ONE;
            state_nxt = S_XRD;
          end
        end
      end
      S_ERD: begin
        if (keep_r[i_r[IW-1:0]]) state_nxt = S_EOUT;
        else i_nxt = i_r + ONE;
      end
      S_EOUT: begin
        if (slot_free) begin
          out_valid_nxt          = 1'b1;
          out_data_nxt.status    = sde_pkg::ST_ELEM;
          out_data_nxt.value_res = xq_r;
          out_data_nxt.count     = 5'(n_r);
          out_data_nxt.last      = (e_r + ONE == n_r);
          if (e_r + ONE == n_r) begin
            state_nxt = S_IDLE;
          end else begin
            e_nxt     = e_r + ONE;
            i_nxt     = i_r + ONE;
            state_nxt = S_ERD;
          end
        end
      end
      S_EMPTY: begin
        if (slot_free) begin
          out_valid_nxt          = 1'b1;
          out_data_nxt.status    = sde_pkg::ST_EMPTY;
          out_data_nxt.value_res = '0;
          out_data_nxt.count     = '0;
          out_data_nxt.last      = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_x_r   <= '0;
      count_y_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_x_r   <= count_x_nxt;
      count_y_r   <= count_y_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    i_r        <= i_nxt;
    j_r        <= j_nxt;
    n_r        <= n_nxt;
    e_r        <= e_nxt;
    keep_r     <= keep_nxt;
    sel_y_r    <= sel_y_nxt;
    dup_r      <= dup_nxt;
    val_r      <= val_nxt;
    xv_r       <= xv_nxt;
    out_data_r <= out_data_nxt;
  end

  // set memories, one write and one registered read each
  always_ff @(posedge clk) begin
    if (wr_x) mem_x[wa] <= val_r;
    xq_r <= mem_x[x_ra];
  end

  always_ff @(posedge clk) begin
    if (wr_y) mem_y[wa] <= val_r;
    yq_r <= mem_y[y_ra];
  end

`ifndef SYNTHESIS
  a_cnt_x_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_x_r <= FULL_CNT) else $error("count_x over capacity");
  a_cnt_y_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_y_r <= FULL_CNT) else $error("count_y over capacity");
  a_cnt_x_step: assert property (@(posedge clk) disable iff (!rst_n)
    (count_x_r != $past(count_x_r)) |-> (count_x_r == $past(count_x_r) + ONE))
    else $error("count_x moved by more than one");
  a_keep_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EOUT) |-> (n_r != '0 && n_r <= count_x_r))
    else $error("difference count out of range");
`endif

endmodule

[sim/set_difference_checker.sv]
// ----------------------------------------------------------------------------
// set_difference_checker
// watches both channels, predicts every result beat and compares it
// ----------------------------------------------------------------------------
module set_difference_checker #(
  parameter int SET_SIZE = sde_pkg::SET_SIZE_DEF
) (
  input  logic  clk,
  input  logic  rst_n,
  sde_in_if.sink  in_mon,
  sde_out_if.sink out_mon,
  output int    fail_count,
  output int    pending,
  output int    beats_seen
);

  logic [63:0]        x_vals[SET_SIZE];
  logic [63:0]        y_vals[SET_SIZE];
  int                 x_cnt;
  int                 y_cnt;
  sde_pkg::out_item_t expected_beats[$];

  // ieee equality written out here on its own
  function automatic bit dbl_equal(logic [63:0] a, logic [63:0] b);
    bit a_nan, b_nan;
    a_nan = (a[62:52] == 11'h7ff) && (a[51:0] != 0);
    b_nan = (b[62:52] == 11'h7ff) && (b[51:0] != 0);
    if (a_nan || b_nan) return 0;
    if (a[62:0] == 0 && b[62:0] == 0) return 1;
    return a == b;
  endfunction

  function automatic bit in_x(logic [63:0] v);
    for (int i = 0; i < x_cnt; i++) if (dbl_equal(x_vals[i], v)) return 1;
    return 0;
  endfunction

  function automatic bit in_y(logic [63:0] v);
    for (int i = 0; i < y_cnt; i++) if (dbl_equal(y_vals[i], v)) return 1;
    return 0;
  endfunction

  task automatic predict_beats(sde_pkg::in_item_t it);
    sde_pkg::out_item_t b;
    logic [63:0]        kept[$];
    bit                 dup;
    if (it.mode == sde_pkg::MODE_LOAD_X || it.mode == sde_pkg::MODE_LOAD_Y) begin
      dup = (it.mode == sde_pkg::MODE_LOAD_X) ? in_x(it.value) : in_y(it.value);
      b.value_res = it.value;
      b.last = 1'b1;
      if (dup) b.status = sde_pkg::ST_DUP;
      else if ((it.mode == sde_pkg::MODE_LOAD_X ? x_cnt : y_cnt) >= SET_SIZE)
        b.status = sde_pkg::ST_FULL;
      else begin
        b.status = sde_pkg::ST_ACCEPT;
        if (it.mode == sde_pkg::MODE_LOAD_X) begin
          x_vals[x_cnt] = it.value;
          x_cnt++;
        end else begin
          y_vals[y_cnt] = it.value;
          y_cnt++;
        end
      end
      b.count = 5'((it.mode == sde_pkg::MODE_LOAD_X) ? x_cnt : y_cnt);
      expected_beats.push_back(b);
    end else if (it.mode == sde_pkg::MODE_COMPUTE) begin
      for (int i = 0; i < x_cnt; i++) if (!in_y(x_vals[i])) kept.push_back(x_vals[i]);
      if (kept.size() == 0) begin
        b = '{status: sde_pkg::ST_EMPTY, value_res: 64'd0, count: 5'd0, last: 1'b1};
        expected_beats.push_back(b);
      end else begin
        foreach (kept[i]) begin
          b.status = sde_pkg::ST_ELEM;
          b.value_res = kept[i];
          b.count = 5'(kept.size());
          b.last = (i == kept.size() - 1);
          expected_beats.push_back(b);
        end
      end
    end
  endtask

  always @(posedge clk) begin
    sde_pkg::out_item_t exp_b;
    sde_pkg::out_item_t got;
    if (!rst_n) begin
      x_cnt = 0;
      y_cnt = 0;
      expected_beats.delete();
      fail_count <= 0;
      beats_seen <= 0;
      pending    <= 0;
    end else begin
      if (in_mon.valid && in_mon.ready) predict_beats(in_mon.data);
      if (out_mon.valid && out_mon.ready) begin
        got = out_mon.data;
        beats_seen <= beats_seen + 1;
        if (expected_beats.size() == 0) begin
          $error("unexpected result beat status=%0d value=%h", got.status, got.value_res);
          fail_count <= fail_count + 1;
        end else begin
          exp_b = expected_beats.pop_front();
          if (got !== exp_b) begin
            fail_count <= fail_count + 1;
            if (got.status !== exp_b.status)
              $error("status: expected %0d, got %0d", exp_b.status, got.status);
            if (got.value_res !== exp_b.value_res)
              $error("value_res: expected %h, got %h", exp_b.value_res, got.value_res);
            if (got.count !== exp_b.count)
              $error("count: expected %0d, got %0d", exp_b.count, got.count);
            if (got.last !== exp_b.last)
              $error("last: expected %0d, got %0d", exp_b.last, got.last);
          end
        end
      end
      pending <= expected_beats.size();
    end
  end
endmodule

[sim/set_difference_engine_unit_tb.sv]
// ----------------------------------------------------------------------------
// set_difference_engine_unit_tb
// drives load and compute beats with random gaps and stalls; the checker
// predicts every result beat and the top gives the verdict
// ----------------------------------------------------------------------------
module set_difference_engine_unit_tb;

  localparam int SET_SIZE = sde_pkg::SET_SIZE_DEF;
  localparam longint CYCLE_LIMIT = 2000000;

  // mode code with no function, consumed without a result
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  logic clk = 0;
  logic rst_n = 0;
  int   fail_count, pending, beats_seen;
  longint cycles = 0;
  int   sent = 0;

  sde_in_if  in_ch ();
  sde_out_if out_ch ();

  set_difference_engine_unit #(.SET_SIZE(SET_SIZE)) uut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch)
  );

  set_difference_checker #(.SET_SIZE(SET_SIZE)) chk (
    .clk(clk), .rst_n(rst_n), .in_mon(in_ch), .out_mon(out_ch),
    .fail_count(fail_count), .pending(pending), .beats_seen(beats_seen)
  );

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  // short gaps mostly, an occasional long one
  function automatic int gap_len();
    if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
    if ($urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 3);
  endfunction

  // receiver stalls run freely; some stretches never stall
  int stall_left = 0;
  bit no_stall = 0;
  initial out_ch.ready = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 0;
    end else if ($urandom_range(0, 199) == 0) begin
      no_stall <= !no_stall;
    end else if (no_stall) begin
      out_ch.ready <= 1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ch.ready <= 0;
    end else begin
      stall_left <= gap_len();
      out_ch.ready <= 1;
    end
  end

  // global watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // one beat, valid held until the handshake; gap before it
  task automatic send_beat(logic [1:0] m, logic [63:0] v, bit use_gap);
    int g;
    g = use_gap ? gap_len() : 0;
    if (g > 0) begin
      in_ch.valid <= 0;
      repeat (g) @(posedge clk);
    end
    in_ch.valid <= 1;
    in_ch.data  <= '{mode: m, value: v};
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sent++;
  endtask

  task automatic drop_valid();
    in_ch.valid <= 0;
    @(posedge clk);
  endtask

  // random double bits, biased toward specials and a small pool for repeats
  function automatic logic [63:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 64'h0000000000000000;
      1: return 64'h8000000000000000;
      2: return {1'b0, 11'h7ff, 44'd0, 8'($urandom_range(1, 255))};
      3: return {$urandom, $urandom};
      default: return 64'h3ff0000000000000 + 64'($urandom_range(0, 11));
    endcase
  endfunction

  localparam logic [63:0] QNAN  = 64'h7ff8000000000000;
  localparam logic [63:0] PZERO = 64'h0000000000000000;
  localparam logic [63:0] NZERO = 64'h8000000000000000;
  localparam logic [63:0] ONE   = 64'h3ff0000000000000;

  initial begin
    int r;
    in_ch.valid = 0;
    in_ch.data  = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: empty sets, zeros, nan, duplicates, mode 3, extremes
    send_beat(sde_pkg::MODE_COMPUTE, 64'd0, 0);
    send_beat(sde_pkg::MODE_LOAD_X, PZERO, 0);
    send_beat(sde_pkg::MODE_LOAD_X, NZERO, 1);          // -0 duplicates +0
    send_beat(sde_pkg::MODE_LOAD_X, QNAN, 0);
    send_beat(sde_pkg::MODE_LOAD_X, QNAN, 0);           // nan never a duplicate
    send_beat(sde_pkg::MODE_LOAD_X, 64'hffffffffffffffff, 1);
    send_beat(sde_pkg::MODE_LOAD_X, ONE, 0);
    send_beat(MODE_UNUSED, 64'hffffffffffffffff, 0);    // unused mode, no result
    send_beat(sde_pkg::MODE_COMPUTE, 64'd0, 0);         // y empty, all of x comes out
    send_beat(sde_pkg::MODE_LOAD_Y, NZERO, 0);
    send_beat(sde_pkg::MODE_LOAD_Y, QNAN, 1);
    send_beat(sde_pkg::MODE_LOAD_Y, ONE, 0);
    send_beat(sde_pkg::MODE_LOAD_Y, ONE, 0);
    send_beat(sde_pkg::MODE_COMPUTE, 64'd0, 1);
    // fill x and y past their size to hit the full case
    for (int i = 0; i < SET_SIZE; i++)
      send_beat(sde_pkg::MODE_LOAD_X, 64'h4000000000000000 + 64'(i), 0);
    for (int i = 0; i < SET_SIZE; i++)
      send_beat(sde_pkg::MODE_LOAD_Y, 64'h4000000000000000 + 64'(i), 0);
    send_beat(sde_pkg::MODE_LOAD_Y, 64'h5555555555555555, 0);
    send_beat(sde_pkg::MODE_COMPUTE, 64'd0, 0);

    // pause until every expected beat has drained
    drop_valid();
    while (pending != 0) @(posedge clk);

    // random phase; sets only fill once, so mostly loads and computes
    for (int n = 0; n < 115; n++) begin
      r = $urandom_range(0, 19);
      if (r < 8) send_beat(sde_pkg::MODE_LOAD_X, pick_value(), 1);
      else if (r < 15) send_beat(sde_pkg::MODE_LOAD_Y, pick_value(), 1);
      else if (r < 19) send_beat(sde_pkg::MODE_COMPUTE, {$urandom, $urandom}, 1);
      else begin
        send_beat(MODE_UNUSED, {$urandom, $urandom}, 1);
        n--;
      end
    end
    drop_valid();

    while (pending != 0) @(posedge clk);
    repeat (400) @(posedge clk);

    $display("sent %0d input beats, checked %0d result beats", sent, beats_seen);
    $display("covered zeros, nan, duplicates, full sets, empty difference, unused mode");
    if (fail_count == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule

[filelist.f]
sv/sde_pkg.sv
sv/sde_if.sv
sv/set_difference_engine_unit.sv
sim/set_difference_checker.sv
sim/set_difference_engine_unit_tb.sv
